// File: rtl/lmp_pkg.sv
// Package for the Legendre monomial product block: fixed-point widths,
// beat payload structs, controller/datapath command and status types and
// the Legendre coefficient tables. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lmp_pkg;

	// Fixed-point format of inputs, results and the running product.
	localparam int FRAC_BITS = 30;
	localparam int DATA_W    = 32;
	localparam int DEG_W     = 4;

	// Horner accumulator: coefficient sums stay below 2^20 times one.
	localparam int MAG_W  = FRAC_BITS + 21;
	localparam int ACC_W  = MAG_W + 1;
	localparam int OPB_W  = FRAC_BITS + 1;
	localparam int LO_W   = (MAG_W + 1) / 2;
	localparam int HI_W   = MAG_W - LO_W;
	localparam int PP_W   = LO_W + OPB_W;
	localparam int PROD_W = MAG_W + OPB_W;

	localparam int COEF_W  = 18;
	localparam int CNT_W   = 3;
	localparam int SHIFT_W = 4;

	localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;
	localparam logic [DEG_W-1:0] MAX_DEGREE = DEG_W'(10);

	typedef struct packed {
		logic signed [DATA_W-1:0] x_value;
		logic [DEG_W-1:0]         degree;
		logic                     last_variable;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] product;
		logic                     bad_degree;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_LO,
		ST_HI,
		ST_SUM,
		ST_WB,
		ST_SCALE,
		ST_EMIT
	} lmp_state_t;

	// Which multiply the shared unit is doing.
	typedef enum logic [1:0] {
		OP_Y,
		OP_HORNER,
		OP_ODD,
		OP_RUN
	} lmp_op_t;

	typedef struct packed {
		logic             load;
		lmp_op_t          op;
		logic             setup;
		logic             mul_lo;
		logic             mul_hi;
		logic             mul_sum;
		logic             wb;
		logic             acc_init;
		logic [CNT_W-1:0] k;
		logic             scale;
		logic             emit;
	} lmp_cmd_t;

	typedef struct packed {
		logic             in_bad;
		logic             in_last;
		logic [CNT_W-1:0] cnt;
		logic             odd;
		logic             last;
		logic             out_free;
	} lmp_sts_t;

	// Number of Horner coefficients for a degree.
	function automatic logic [CNT_W-1:0] cnt_of(input logic [DEG_W-1:0] deg);
		logic [CNT_W-1:0] c;
		case (deg)
			4'd0, 4'd1: c = 3'd1;
			4'd2, 4'd3: c = 3'd2;
			4'd4, 4'd5: c = 3'd3;
			4'd6, 4'd7: c = 3'd4;
			4'd8, 4'd9: c = 3'd5;
			4'd10:      c = 3'd6;
			default:    c = 3'd1;
		endcase
		return c;
	endfunction

	// Odd degrees finish with one multiply by x.
	function automatic logic odd_of(input logic [DEG_W-1:0] deg);
		return deg[0];
	endfunction

	// Power of two that divides the integer coefficients.
	function automatic logic [SHIFT_W-1:0] shift_of(input logic [DEG_W-1:0] deg);
		logic [SHIFT_W-1:0] s;
		case (deg)
			4'd0, 4'd1: s = 4'd0;
			4'd2, 4'd3: s = 4'd1;
			4'd4, 4'd5: s = 4'd3;
			4'd6, 4'd7: s = 4'd4;
			4'd8, 4'd9: s = 4'd7;
			4'd10:      s = 4'd8;
			default:    s = 4'd0;
		endcase
		return s;
	endfunction

	// Integer coefficients, highest power of x first.
	function automatic logic signed [COEF_W-1:0] coef_of(input logic [DEG_W-1:0] deg,
		input logic [CNT_W-1:0] k);
		logic signed [COEF_W-1:0] c;
		case ({deg, k})
			{4'd0, 3'd0}:  c = 18'sd1;
			{4'd1, 3'd0}:  c = 18'sd1;
			{4'd2, 3'd0}:  c = 18'sd3;
			{4'd2, 3'd1}:  c = -18'sd1;
			{4'd3, 3'd0}:  c = 18'sd5;
			{4'd3, 3'd1}:  c = -18'sd3;
			{4'd4, 3'd0}:  c = 18'sd35;
			{4'd4, 3'd1}:  c = -18'sd30;
			{4'd4, 3'd2}:  c = 18'sd3;
			{4'd5, 3'd0}:  c = 18'sd63;
			{4'd5, 3'd1}:  c = -18'sd70;
			{4'd5, 3'd2}:  c = 18'sd15;
			{4'd6, 3'd0}:  c = 18'sd231;
			{4'd6, 3'd1}:  c = -18'sd315;
			{4'd6, 3'd2}:  c = 18'sd105;
			{4'd6, 3'd3}:  c = -18'sd5;
			{4'd7, 3'd0}:  c = 18'sd429;
			{4'd7, 3'd1}:  c = -18'sd693;
			{4'd7, 3'd2}:  c = 18'sd315;
			{4'd7, 3'd3}:  c = -18'sd35;
			{4'd8, 3'd0}:  c = 18'sd6435;
			{4'd8, 3'd1}:  c = -18'sd12012;
			{4'd8, 3'd2}:  c = 18'sd6930;
			{4'd8, 3'd3}:  c = -18'sd1260;
			{4'd8, 3'd4}:  c = 18'sd35;
			{4'd9, 3'd0}:  c = 18'sd12155;
			{4'd9, 3'd1}:  c = -18'sd25740;
			{4'd9, 3'd2}:  c = 18'sd18018;
			{4'd9, 3'd3}:  c = -18'sd4620;
			{4'd9, 3'd4}:  c = 18'sd315;
			{4'd10, 3'd0}: c = 18'sd46189;
			{4'd10, 3'd1}: c = -18'sd109395;
			{4'd10, 3'd2}: c = 18'sd90090;
			{4'd10, 3'd3}: c = -18'sd30030;
			{4'd10, 3'd4}: c = 18'sd3465;
			{4'd10, 3'd5}: c = -18'sd63;
			default:       c = 18'sd0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/lmp_ctrl.sv
// Controller of the Legendre monomial product block: sequences the shared
// multiplier through the Horner steps and the product update.
// Depends on lmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lmp_pkg::lmp_sts_t sts,
	output lmp_pkg::lmp_cmd_t cmd
);
	import lmp_pkg::*;

	lmp_state_t       state_q, state_d;
	lmp_op_t          op_q, op_d;
	logic [CNT_W-1:0] k_q, k_d;

	// State, current multiply and coefficient index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_Y;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			k_q     <= k_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		k_d        = k_q;
		cmd        = '0;
		cmd.op     = op_q;
		cmd.k      = k_q;
		item_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					if (sts.in_bad) begin
						// The factor is one, so only the flag changes.
						state_d = sts.in_last ? ST_EMIT : ST_IDLE;
					end else begin
						op_d    = OP_Y;
						k_d     = '0;
						state_d = ST_SETUP;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_LO;
			end
			ST_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_HI;
			end
			ST_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.mul_sum = 1'b1;
				state_d     = ST_WB;
			end
			ST_WB: begin
				cmd.wb = 1'b1;
				unique case (op_q)
					OP_Y: begin
						cmd.acc_init = 1'b1;
						if (sts.cnt > CNT_W'(1)) begin
							op_d    = OP_HORNER;
							k_d     = CNT_W'(1);
							state_d = ST_SETUP;
						end else if (sts.odd) begin
							op_d    = OP_ODD;
							state_d = ST_SETUP;
						end else begin
							state_d = ST_SCALE;
						end
					end
					OP_HORNER: begin
						if (CNT_W'(k_q + 1'b1) < sts.cnt) begin
							k_d     = CNT_W'(k_q + 1'b1);
							state_d = ST_SETUP;
						end else if (sts.odd) begin
							op_d    = OP_ODD;
							state_d = ST_SETUP;
						end else begin
							state_d = ST_SCALE;
						end
					end
					OP_ODD: begin
						state_d = ST_SCALE;
					end
					OP_RUN: begin
						state_d = sts.last ? ST_EMIT : ST_IDLE;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				op_d      = OP_RUN;
				state_d   = ST_SETUP;
			end
			ST_EMIT: begin
				// Wait until the output register can take the result.
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/lmp_datapath.sv
// Datapath of the Legendre monomial product block: operand registers, the
// shared split multiplier, Horner accumulator, running product and output
// register. Depends on lmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmp_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  lmp_pkg::lmp_cmd_t cmd,
	output lmp_pkg::lmp_sts_t sts,
	input  lmp_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output lmp_pkg::result_t  result
);
	import lmp_pkg::*;

	localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] ONE_W = ACC_W'(ONE_Q);

	logic signed [DATA_W-1:0] x_q, y_q, run_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [DEG_W-1:0]         deg_q;
	logic                     last_q, err_q;
	logic [MAG_W-1:0]         ma_q;
	logic [OPB_W-1:0]         mb_q;
	logic                     neg_q;
	logic [PP_W-1:0]          pp_s1;
	logic [PROD_W-1:0]        prod_q;
	logic                     out_valid_q;
	result_t                  out_q;

	logic signed [DATA_W-1:0] x_clamped;
	logic signed [ACC_W-1:0]  opa;
	logic signed [DATA_W-1:0] opb;
	logic [ACC_W-1:0]         opa_abs;
	logic [DATA_W-1:0]        opb_abs;
	logic [ACC_W-1:0]         res_mag;
	logic signed [ACC_W-1:0]  res;
	logic signed [ACC_W-1:0]  coef_ext;
	logic signed [DATA_W-1:0] run_next;
	logic [SHIFT_W-1:0]       sh;
	logic [ACC_W-1:0]         acc_abs;
	logic [ACC_W:0]           rsum, rshift;
	logic [OPB_W-1:0]         p_mag;
	logic signed [OPB_W:0]    p_val;

	// Input saturated to plus or minus one.
	always_comb begin
		if (item.x_value > ONE_Q) begin
			x_clamped = ONE_Q;
		end else if (item.x_value < -ONE_Q) begin
			x_clamped = -ONE_Q;
		end else begin
			x_clamped = item.x_value;
		end
	end

	// Operand selection and magnitudes for the multiplier.
	always_comb begin
		case (cmd.op)
			OP_Y: begin
				opa = ACC_W'(x_q);
				opb = x_q;
			end
			OP_HORNER: begin
				opa = acc_q;
				opb = y_q;
			end
			OP_ODD: begin
				opa = acc_q;
				opb = x_q;
			end
			default: begin
				opa = ACC_W'(run_q);
				opb = $signed(acc_q[DATA_W-1:0]);
			end
		endcase
		opa_abs = opa[ACC_W-1] ? (~opa + 1'b1) : opa;
		opb_abs = opb[DATA_W-1] ? (~opb + 1'b1) : opb;
	end

	// Rounded, signed result of the multiply, and the coefficient in Q format.
	always_comb begin
		res_mag  = prod_q[PROD_W-1:FRAC_BITS];
		res      = neg_q ? -$signed(res_mag) : $signed(res_mag);
		coef_ext = ACC_W'(coef_of(deg_q, cmd.k)) <<< FRAC_BITS;
		if (res > ONE_W) begin
			run_next = ONE_Q;
		end else if (res < -ONE_W) begin
			run_next = -ONE_Q;
		end else begin
			run_next = res[DATA_W-1:0];
		end
	end

	// Divide by the coefficient scale with rounding, then clamp to one.
	always_comb begin
		sh      = shift_of(deg_q);
		acc_abs = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
		rsum    = {1'b0, acc_abs} + (((ACC_W+1)'(1) << sh) >> 1);
		rshift  = rsum >> sh;
		if (rshift > (ACC_W+1)'(ONE_Q)) begin
			p_mag = OPB_W'(ONE_Q);
		end else begin
			p_mag = rshift[OPB_W-1:0];
		end
		p_val = acc_q[ACC_W-1] ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
	end

	// Item fields, multiplier operands and partial products.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= x_clamped;
			deg_q  <= item.degree;
			last_q <= item.last_variable;
		end
		if (cmd.setup) begin
			ma_q  <= opa_abs[MAG_W-1:0];
			mb_q  <= opb_abs[OPB_W-1:0];
			neg_q <= opa[ACC_W-1] ^ opb[DATA_W-1];
		end
		if (cmd.mul_lo) begin
			pp_s1 <= PP_W'(ma_q[LO_W-1:0]) * PP_W'(mb_q);
		end
		if (cmd.mul_hi) begin
			prod_q <= PROD_W'(pp_s1) + HALF;
			pp_s1  <= PP_W'(ma_q[MAG_W-1:LO_W]) * PP_W'(mb_q);
		end
		if (cmd.mul_sum) begin
			prod_q <= prod_q + (PROD_W'(pp_s1) << LO_W);
		end
		if (cmd.wb && cmd.op == OP_Y) begin
			y_q <= res[DATA_W-1:0];
		end
		// Horner accumulator.
		if (cmd.acc_init) begin
			acc_q <= coef_ext;
		end else if (cmd.wb && cmd.op == OP_HORNER) begin
			acc_q <= res + coef_ext;
		end else if (cmd.wb && cmd.op == OP_ODD) begin
			acc_q <= res;
		end else if (cmd.scale) begin
			acc_q <= ACC_W'(p_val);
		end
		if (cmd.emit) begin
			out_q.product    <= run_q;
			out_q.bad_degree <= err_q;
		end
	end

	// Running product, sticky flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= ONE_Q;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				run_q <= ONE_Q;
			end else if (cmd.wb && cmd.op == OP_RUN) begin
				run_q <= run_next;
			end
			if (cmd.load && sts.in_bad) begin
				err_q <= 1'b1;
			end else if (cmd.emit) begin
				err_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Status back to the controller.
	always_comb begin
		sts.in_bad   = (item.degree > MAX_DEGREE);
		sts.in_last  = item.last_variable;
		sts.cnt      = cnt_of(deg_q);
		sts.odd      = odd_of(deg_q);
		sts.last     = last_q;
		sts.out_free = !out_valid_q || !result_stall;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// File: rtl/legendre_monomial_product.sv
// Legendre monomial product: one item (x, degree) at a time; the result beat follows a last item.
// An item takes m + 1 multiplies, m = ceil((degree+1)/2) + (degree odd), plus the idle and scale
// states; each multiply runs setup, lo, hi, sum and write-back on the shared split multiplier.
// Degrees over 10 skip the multiplies; a last item then emits and result_valid rises next cycle.
// Reset clears the sequencer and the output valid, sets the product to 1.0 and the flag to 0.
`timescale 1ns / 1ps
`default_nettype none

module legendre_monomial_product (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  lmp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output lmp_pkg::result_t result
);
	import lmp_pkg::*;

	lmp_cmd_t cmd;
	lmp_sts_t sts;

	// Sequencer.
	lmp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Arithmetic and storage.
	lmp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// A result beat appears only after the controller has emitted one.
	a_valid_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.emit))
		else $error("result beat without an emit command");

	// Emitting never overwrites a result that is still waiting.
	a_emit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("emit while the output register is held");

	// A bad degree that is not last passes straight through.
	a_bad_degree_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && (item.degree > MAX_DEGREE) && !item.last_variable)
		|=> !item_stall)
		else $error("bad-degree beat did not return to idle");

	// The emitted product stays within plus or minus one.
	a_product_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.product <= ONE_Q) && (result.product >= -ONE_Q))
		else $error("product beyond saturation limits");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for legendre_monomial_product: a directed table followed by random
// monomials, each result checked against a table value or a bit-exact fixed-point predictor.
// Depends on lmp_pkg and the legendre_monomial_product block.
`timescale 1ns / 1ps

module testbench;
	import lmp_pkg::*;

	localparam longint UNIT         = longint'(1) << FRAC_BITS;
	localparam int     RANDOM_ITEMS = 1630;
	localparam int     MODE_ITEMS   = 200;
	localparam int     QUIET_LIMIT  = 4000;
	localparam int     HOLD_CYCLES  = 300;
	localparam int     HOLD_AT      = 500;
	localparam int     HOLD_BURST   = 16;
	localparam int     PAUSE_AT     = 1000;
	localparam int     DRAIN_CYCLES = 60;

	typedef enum logic [1:0] {
		MODE_STEADY,
		MODE_SENDER_GAPS,
		MODE_RECEIVER_STALLS,
		MODE_BOTH
	} idle_mode_t;

	typedef struct {
		item_t   beat;
		bit      typed;
		result_t want;
	} stim_row_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_stall;
	item_t      item         = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	result_t    result;

	idle_mode_t idle_mode = MODE_STEADY;
	int         hold_req  = 0;
	int         hold_ack  = 0;
	int         hold_left = 0;
	int         fail_count = 0;
	result_t    pending_products[$];
	longint     run_product;
	bit         run_bad;

	legendre_monomial_product dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Percentage of cycles in which each side holds back, per idling mode.
	function automatic int gap_pct(input idle_mode_t m);
		case (m)
			MODE_SENDER_GAPS: return 47;
			MODE_BOTH:        return 35;
			default:          return 0;
		endcase
	endfunction

	function automatic int stall_pct(input idle_mode_t m);
		case (m)
			MODE_RECEIVER_STALLS: return 47;
			MODE_BOTH:            return 35;
			default:              return 0;
		endcase
	endfunction

	// Rounded fixed-point product a*b / 2^F, ties away from zero.
	function automatic longint mul_q(input longint a, input longint b);
		longint unsigned ma, mb, p;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = (ma >> FRAC_BITS) * mb + (((ma & (UNIT - 1)) * mb + (UNIT >> 1)) >> FRAC_BITS);
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint clamp_unit(input longint v);
		if (v > UNIT)
			return UNIT;
		if (v < -UNIT)
			return -UNIT;
		return v;
	endfunction

	// Legendre value of x by Horner steps in x squared, scaled down by a power of two.
	function automatic longint legendre_q(input longint x, input logic [DEG_W-1:0] deg);
		longint          coef [6];
		int              terms, scale;
		longint          y, acc;
		longint unsigned mag;
		case (deg)
			4'd2:  begin terms = 2; scale = 1; coef = '{3, -1, 0, 0, 0, 0}; end
			4'd3:  begin terms = 2; scale = 1; coef = '{5, -3, 0, 0, 0, 0}; end
			4'd4:  begin terms = 3; scale = 3; coef = '{35, -30, 3, 0, 0, 0}; end
			4'd5:  begin terms = 3; scale = 3; coef = '{63, -70, 15, 0, 0, 0}; end
			4'd6:  begin terms = 4; scale = 4; coef = '{231, -315, 105, -5, 0, 0}; end
			4'd7:  begin terms = 4; scale = 4; coef = '{429, -693, 315, -35, 0, 0}; end
			4'd8:  begin terms = 5; scale = 7; coef = '{6435, -12012, 6930, -1260, 35, 0}; end
			4'd9:  begin terms = 5; scale = 7; coef = '{12155, -25740, 18018, -4620, 315, 0}; end
			4'd10: begin
				terms = 6;
				scale = 8;
				coef = '{46189, -109395, 90090, -30030, 3465, -63};
			end
			default: begin terms = 1; scale = 0; coef = '{1, 0, 0, 0, 0, 0}; end
		endcase
		y = mul_q(x, x);
		acc = coef[0] * UNIT;
		for (int k = 1; k < terms; k++)
			acc = mul_q(acc, y) + coef[k] * UNIT;
		// Odd degrees carry one extra factor of x.
		if (deg[0])
			acc = mul_q(acc, x);
		if (scale > 0) begin
			mag = (acc < 0) ? -acc : acc;
			mag = (mag + (longint'(1) << (scale - 1))) >> scale;
			acc = (acc < 0) ? -longint'(mag) : longint'(mag);
		end
		return clamp_unit(acc);
	endfunction

	// Fold one accepted item into the running product; returns 1 when a result is due.
	function automatic bit fold_item(input item_t beat, output result_t due);
		longint x, p;
		x = clamp_unit(longint'(beat.x_value));
		if (beat.degree > MAX_DEGREE) begin
			run_bad = 1'b1;
			p = UNIT;
		end else begin
			p = legendre_q(x, beat.degree);
		end
		run_product = clamp_unit(mul_q(clamp_unit(run_product), p));
		due.product = run_product[DATA_W-1:0];
		due.bad_degree = run_bad;
		if (!beat.last_variable)
			return 1'b0;
		run_product = UNIT;
		run_bad = 1'b0;
		return 1'b1;
	endfunction

	function automatic stim_row_t stim_row(input logic [DATA_W-1:0] x, input int deg,
		input bit closes, input bit typed, input logic [DATA_W-1:0] product, input bit bad);
		stim_row_t r;
		r.beat.x_value = x;
		r.beat.degree = DEG_W'(deg);
		r.beat.last_variable = closes;
		r.typed = typed;
		r.want.product = product;
		r.want.bad_degree = bad;
		return r;
	endfunction

	// Mostly in-range inputs, with a share of full-width values and exact end points.
	function automatic item_t random_item(input bit closes);
		item_t beat;
		int    pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			beat.x_value = $urandom;
		end else if (pick < 16) begin
			case ($urandom_range(2))
				0:       beat.x_value = ONE_Q;
				1:       beat.x_value = -ONE_Q;
				default: beat.x_value = '0;
			endcase
		end else begin
			beat.x_value = DATA_W'(longint'($urandom_range(32'h8000_0000)) - UNIT);
		end
		beat.degree = ($urandom_range(99) < 8) ? DEG_W'($urandom_range(15, 11))
			: DEG_W'($urandom_range(10));
		beat.last_variable = closes;
		return beat;
	endfunction

	// Offer one beat, wait for it to be taken, then record what it should produce.
	// Valid stays high after acceptance; the next call or the caller decides what follows.
	task automatic issue(input item_t beat, input bit typed, input result_t want, input int gaps);
		result_t due;
		while ($urandom_range(99) < gaps) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= beat;
		do @(posedge clk); while (item_stall !== 1'b0);
		if (fold_item(beat, due))
			pending_products.push_back(typed ? want : due);
	endtask

	// Result side: check each accepted beat and drive the stall pattern.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_products.size() == 0) begin
				$error("unexpected result beat: product %0d, bad_degree %0b",
					result.product, result.bad_degree);
				fail_count++;
			end else begin
				want = pending_products.pop_front();
				if (result.product !== want.product) begin
					$error("product: expected %0d, actual %0d", want.product, result.product);
					fail_count++;
				end
				if (result.bad_degree !== want.bad_degree) begin
					$error("bad_degree: expected %0b, actual %0b",
						want.bad_degree, result.bad_degree);
					fail_count++;
				end
			end
		end
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct(idle_mode));
		end
	end

	// Ends the run if neither channel moves a beat for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		stim_row_t  rows[$];
		idle_mode_t mode;
		int         left_in_monomial;
		bit         closes;
		run_product = UNIT;
		run_bad = 1'b0;

		// Directed table: end points, saturation of x, bad degrees and every degree.
		rows.push_back(stim_row(32'h0, 0, 1'b1, 1'b1, ONE_Q, 1'b0));
		rows.push_back(stim_row(ONE_Q, 10, 1'b1, 1'b1, ONE_Q, 1'b0));
		rows.push_back(stim_row(-ONE_Q, 9, 1'b1, 1'b1, -ONE_Q, 1'b0));
		rows.push_back(stim_row(32'h7FFF_FFFF, 1, 1'b1, 1'b1, ONE_Q, 1'b0));
		rows.push_back(stim_row(32'h8000_0000, 1, 1'b1, 1'b1, -ONE_Q, 1'b0));
		rows.push_back(stim_row(32'h1234_5678, 15, 1'b1, 1'b1, ONE_Q, 1'b1));
		rows.push_back(stim_row(32'h2000_0000, 11, 1'b0, 1'b0, '0, 1'b0));
		rows.push_back(stim_row(32'h2000_0000, 3, 1'b1, 1'b0, '0, 1'b0));
		rows.push_back(stim_row(32'h3000_0000, 2, 1'b0, 1'b0, '0, 1'b0));
		rows.push_back(stim_row(32'hF000_0000, 4, 1'b0, 1'b0, '0, 1'b0));
		rows.push_back(stim_row(32'h1234_5678, 5, 1'b0, 1'b0, '0, 1'b0));
		rows.push_back(stim_row(32'hDCBA_9877, 6, 1'b0, 1'b0, '0, 1'b0));
		rows.push_back(stim_row(32'h0ABC_DEF0, 7, 1'b0, 1'b0, '0, 1'b0));
		rows.push_back(stim_row(32'hC000_0001, 8, 1'b1, 1'b0, '0, 1'b0));
		rows.push_back(stim_row(32'h3FFF_FFFF, 12, 1'b0, 1'b0, '0, 1'b0));
		rows.push_back(stim_row(32'h0000_0001, 13, 1'b0, 1'b0, '0, 1'b0));
		rows.push_back(stim_row(32'hFFFF_FFFF, 14, 1'b1, 1'b1, ONE_Q, 1'b1));
		rows.push_back(stim_row(32'h0, 1, 1'b1, 1'b1, 32'h0, 1'b0));
		rows.push_back(stim_row(32'h0, 2, 1'b1, 1'b1, 32'hE000_0000, 1'b0));
		rows.push_back(stim_row(32'h4000_0001, 3, 1'b1, 1'b1, ONE_Q, 1'b0));
		rows.push_back(stim_row(32'h0, 10, 1'b1, 1'b0, '0, 1'b0));
		rows.push_back(stim_row(32'h2000_0000, 10, 1'b0, 1'b0, '0, 1'b0));
		rows.push_back(stim_row(32'hE000_0000, 6, 1'b1, 1'b0, '0, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			issue(rows[i].beat, rows[i].typed, rows[i].want, 0);

		// Random monomials, cycling through the idling modes.
		left_in_monomial = 0;
		mode = MODE_STEADY;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % MODE_ITEMS == 0) begin
				mode = idle_mode_t'((n / MODE_ITEMS) % 4);
				idle_mode <= mode;
			end
			// Long receiver hold while short monomials keep arriving, to back the block up.
			if (n == HOLD_AT)
				hold_req <= hold_req + 1;
			// Let the block drain completely before carrying on.
			if (n == PAUSE_AT) begin
				item_valid <= 1'b0;
				while (pending_products.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			if (left_in_monomial == 0)
				left_in_monomial = ($urandom_range(9) == 0) ? $urandom_range(8, 5)
					: $urandom_range(4, 1);
			if ((n >= HOLD_AT && n < HOLD_AT + HOLD_BURST) || n == RANDOM_ITEMS - 1)
				left_in_monomial = 1;
			left_in_monomial--;
			closes = (left_in_monomial == 0);
			issue(random_item(closes), 1'b0, '0, gap_pct(mode));
		end
		item_valid <= 1'b0;

		while (pending_products.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_products.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
